// File: hw/rtl/pqrid_pkg.sv
// package for the sorted priority queue with replace by id
// constants, opcode and status codes, controller/datapath command and status types
package pqrid_pkg;

  localparam int unsigned QueueDepth = 16;
  localparam int unsigned IdBits     = 32;
  localparam int unsigned IdxBits    = $clog2(QueueDepth);
  localparam int unsigned CntBits    = $clog2(QueueDepth + 1);
  localparam int unsigned PriBits    = 16;

  localparam logic [1:0] OpAdd    = 2'd0;
  localparam logic [1:0] OpRemove = 2'd1;
  localparam logic [1:0] OpTake   = 2'd2;
  localparam logic [1:0] OpUnused = 2'd3;

  localparam logic [2:0] StOk         = 3'd0;
  localparam logic [2:0] StNotFound   = 3'd1;
  localparam logic [2:0] StFull       = 3'd2;
  localparam logic [2:0] StInProcess  = 3'd3;
  localparam logic [2:0] StEmpty      = 3'd4;

  typedef enum logic [2:0] {
    CmdNone,
    CmdLoad,
    CmdScan,
    CmdDrop,
    CmdPut,
    CmdTake,
    CmdBounds
  } cmd_e;

  typedef struct packed {
    cmd_e cmd;
  } dp_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic drop_done;
    logic put_done;
    logic full;
    logic found;
  } dp_stat_t;

endpackage

// File: hw/rtl/pqrid_ctrl.sv
// controller state machine for the priority queue
// depends on pqrid_pkg; drives commands to pqrid_dp
module pqrid_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic [1:0]         op_i,
  output logic               in_stall_o,
  input  logic               out_stall_i,
  output logic               out_valid_o,
  output pqrid_pkg::dp_cmd_t cmd_o,
  input  pqrid_pkg::dp_stat_t stat_i
);
  import pqrid_pkg::*;

  localparam logic [2:0] SIdle  = 3'd0;
  localparam logic [2:0] SScan  = 3'd1;
  localparam logic [2:0] SDrop  = 3'd2;
  localparam logic [2:0] SPut   = 3'd3;
  localparam logic [2:0] SBound = 3'd4;
  localparam logic [2:0] SOut   = 3'd5;

  logic [2:0] state_q, state_d;
  logic [1:0] op_q, op_d;
  logic       accept;

  assign in_stall_o  = (state_q != SIdle);
  assign out_valid_o = (state_q == SOut);
  assign accept      = in_valid_i && (state_q == SIdle);

  always_comb begin
    state_d   = state_q;
    op_d      = op_q;
    cmd_o.cmd = CmdNone;
    unique case (state_q)
      SIdle: begin
        if (accept) begin
          cmd_o.cmd = CmdLoad;
          op_d      = op_i;
          state_d   = SScan;
        end
      end
      SScan: begin
        priority if (op_q == OpTake) begin
          cmd_o.cmd = CmdTake;
          state_d   = SOut;
        end else if (op_q == OpAdd && stat_i.full) begin
          state_d = SOut;
        end else if (op_q != OpAdd && op_q != OpRemove) begin
          state_d = SOut;
        end else if (!stat_i.scan_done) begin
          cmd_o.cmd = CmdScan;
        end else if (op_q == OpRemove && !stat_i.found) begin
          state_d = SOut;
        end else if (stat_i.found) begin
          state_d = SDrop;
        end else begin
          state_d = SPut;
        end
      end
      SDrop: begin
        cmd_o.cmd = CmdDrop;
        if (stat_i.drop_done) state_d = (op_q == OpAdd) ? SPut : SBound;
      end
      SPut: begin
        cmd_o.cmd = CmdPut;
        if (stat_i.put_done) state_d = SBound;
      end
      SBound: begin
        cmd_o.cmd = CmdBounds;
        state_d   = SOut;
      end
      SOut: begin
        if (!out_stall_i) state_d = SIdle;
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      op_q    <= OpAdd;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
    end
  end

`ifndef SYNTH
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != SIdle |-> in_stall_o)
    else $error("request accepted while busy");
  a_load_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.cmd == CmdLoad |-> state_q == SIdle)
    else $error("load outside idle");
`endif
endmodule

// File: hw/rtl/pqrid_dp.sv
// datapath of the priority queue: slot registers, scan pointer and bounds
// depends on pqrid_pkg; commanded by pqrid_ctrl
module pqrid_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [1:0]                    op_i,
  input  logic [pqrid_pkg::IdBits-1:0]  entry_id_i,
  input  logic signed [pqrid_pkg::PriBits-1:0] entry_priority_i,
  input  logic                          id_from_user_i,
  input  pqrid_pkg::dp_cmd_t            cmd_i,
  output pqrid_pkg::dp_stat_t           stat_o,
  output logic [2:0]                    status_o,
  output logic [pqrid_pkg::IdBits-1:0]  head_id_o,
  output logic signed [pqrid_pkg::PriBits-1:0] head_priority_o,
  output logic                          head_valid_o,
  output logic                          from_empty_o,
  output logic                          replaced_o,
  output logic [pqrid_pkg::CntBits-1:0] entry_count_o
);
  import pqrid_pkg::*;

  logic [IdBits-1:0]         id_q [QueueDepth];
  logic signed [PriBits-1:0] pri_q [QueueDepth];
  logic [QueueDepth-1:0]     busy_q;
  logic [CntBits-1:0]        occ_q;
  logic signed [PriBits-1:0] hi_q, lo_q;
  logic                      user_q;

  // per-request registers
  logic [1:0]                op_q;
  logic [IdBits-1:0]         rid_q;
  logic signed [PriBits-1:0] rpri_q;
  logic [CntBits-1:0]        i_q;     // scan pointer
  logic [IdxBits-1:0]        ins_q, drop_q;
  logic                      ins_set_q, found_q, scan_en_q, done_q;
  logic [2:0]                status_q;
  logic                      from_empty_q, replaced_q;
  logic [CntBits-1:0]        sh_q;    // shift position

  logic [IdxBits-1:0] ii;
  logic               in_rng;
  logic [IdxBits-1:0] put_pos;
  logic [IdxBits-1:0] occ_idx, last_idx;

  assign ii       = i_q[IdxBits-1:0];
  assign occ_idx  = occ_q[IdxBits-1:0];
  assign last_idx = IdxBits'(occ_q - CntBits'(1));
  assign in_rng   = (entry_priority_i > lo_q) && (entry_priority_i <= hi_q);
  assign put_pos  = ins_set_q ? ins_q : ((rpri_q > hi_q) ? '0 : occ_idx);

  assign stat_o.scan_done = done_q;
  assign stat_o.full      = (occ_q >= CntBits'(QueueDepth));
  assign stat_o.found     = found_q;
  assign stat_o.drop_done = (sh_q + CntBits'(1) >= occ_q);
  assign stat_o.put_done  = (sh_q <= {1'b0, put_pos});

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.cmd)
      CmdDrop: if (sh_q + CntBits'(1) < occ_q) begin
        id_q[sh_q[IdxBits-1:0]]  <= id_q[IdxBits'(sh_q + CntBits'(1))];
        pri_q[sh_q[IdxBits-1:0]] <= pri_q[IdxBits'(sh_q + CntBits'(1))];
      end
      CmdPut: begin
        if (sh_q > {1'b0, put_pos}) begin
          id_q[sh_q[IdxBits-1:0]]  <= id_q[IdxBits'(sh_q - CntBits'(1))];
          pri_q[sh_q[IdxBits-1:0]] <= pri_q[IdxBits'(sh_q - CntBits'(1))];
        end else begin
          id_q[put_pos]  <= rid_q;
          pri_q[put_pos] <= rpri_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= '0; occ_q <= '0; hi_q <= '0; lo_q <= '0; user_q <= 1'b0;
      op_q <= OpAdd; rid_q <= '0; rpri_q <= '0; i_q <= '0; ins_q <= '0;
      drop_q <= '0; ins_set_q <= 1'b0; found_q <= 1'b0; scan_en_q <= 1'b0;
      done_q <= 1'b0; status_q <= StOk; from_empty_q <= 1'b0;
      replaced_q <= 1'b0; sh_q <= '0;
    end else begin
      unique case (cmd_i.cmd)
        CmdLoad: begin
          op_q        <= op_i;
          rid_q       <= entry_id_i;
          rpri_q      <= entry_priority_i;
          i_q         <= '0;
          ins_set_q   <= 1'b0;
          found_q     <= 1'b0;
          replaced_q  <= 1'b0;
          done_q      <= 1'b0;
          if (op_i == OpAdd && occ_q < CntBits'(QueueDepth)) begin
            status_q     <= StOk;
            from_empty_q <= (occ_q == '0);
            user_q       <= user_q | id_from_user_i;
            scan_en_q    <= user_q | id_from_user_i | in_rng;
          end else begin
            from_empty_q <= 1'b0;
            scan_en_q    <= 1'b1;
            if (op_i == OpAdd) status_q <= StFull;
            else if (op_i == OpRemove) status_q <= StNotFound;
            else status_q <= StOk;
          end
        end
        CmdScan: begin
          // one slot per cycle; the scan index steps through every slot, the matched one included
          if (!scan_en_q || i_q >= occ_q
              || (op_q == OpAdd && ins_set_q && found_q)) begin
            done_q <= 1'b1;
            // a put without a drop starts shifting at the tail
            sh_q   <= found_q ? {1'b0, drop_q} : occ_q;
          end else begin
            if (op_q == OpAdd && !ins_set_q && rpri_q > pri_q[ii]) begin
              ins_set_q <= 1'b1;
              // after a drop the slots past it move up by one
              ins_q     <= found_q ? IdxBits'(ii - IdxBits'(1)) : ii;
            end
            if (!found_q && id_q[ii] == rid_q) begin
              found_q <= 1'b1;
              drop_q  <= ii;
              if (op_q == OpRemove) begin
                done_q   <= 1'b1;
                status_q <= StOk;
                sh_q     <= {1'b0, ii};
              end
            end
            i_q <= i_q + CntBits'(1);
          end
        end
        CmdDrop: begin
          busy_q[sh_q[IdxBits-1:0]] <= (sh_q + CntBits'(1) < occ_q)
            ? busy_q[IdxBits'(sh_q + CntBits'(1))] : 1'b0;
          if (sh_q + CntBits'(1) >= occ_q) begin
            occ_q      <= occ_q - CntBits'(1);
            replaced_q <= (op_q == OpAdd);
            sh_q       <= occ_q - CntBits'(1);
          end else begin
            sh_q <= sh_q + CntBits'(1);
          end
        end
        CmdPut: begin
          if (sh_q > {1'b0, put_pos}) begin
            busy_q[sh_q[IdxBits-1:0]] <= busy_q[IdxBits'(sh_q - CntBits'(1))];
            sh_q <= sh_q - CntBits'(1);
          end else begin
            busy_q[put_pos] <= 1'b0;
            occ_q <= occ_q + CntBits'(1);
          end
        end
        CmdTake: begin
          if (occ_q == '0) status_q <= StEmpty;
          else if (busy_q[0]) status_q <= StInProcess;
          else busy_q[0] <= 1'b1;
        end
        CmdBounds: begin
          if (occ_q != '0) begin
            hi_q <= pri_q[0];
            lo_q <= pri_q[last_idx];
          end
        end
        default: ;
      endcase
    end
  end

  assign status_o        = status_q;
  assign head_valid_o    = (occ_q != '0);
  assign head_id_o       = head_valid_o ? id_q[0] : '0;
  assign head_priority_o = head_valid_o ? pri_q[0] : '0;
  assign from_empty_o    = from_empty_q;
  assign replaced_o      = replaced_q;
  assign entry_count_o   = occ_q;

`ifndef SYNTH
  a_occ_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= CntBits'(QueueDepth))
    else $error("occupancy overflow");
  a_put_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.cmd == CmdPut && sh_q <= {1'b0, put_pos} |=> occ_q == $past(occ_q) + CntBits'(1))
    else $error("put did not add an entry");
  a_take_marks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.cmd == CmdTake && occ_q != '0 |=> busy_q[0])
    else $error("take left head idle");
`endif
endmodule

// File: hw/rtl/priority_queue_replace_by_id_top.sv
// top level of the sorted priority queue with replace by id
// depends on pqrid_pkg, pqrid_ctrl, pqrid_dp
//
// channel | direction | handshake            | payload
// in      | input     | in_valid_i/in_stall_o  | op, entry_id, entry_priority, id_from_user
// out     | output    | out_valid_o/out_stall_i| status, head_*, from_empty, replaced, entry_count
//
// one request at a time; take, full adds and the unused code skip the scan, shifts and bounds
// add and remove scan one slot a cycle, then shift one slot a cycle:
// an add runs the scan, the drop shift and the insert shift, each over up to 16 slots,
// so its run time is set by the single slot scan/shift loop
// reset clears occupancy, in-process bits and bounds; slot data needs none
// the result holds while out_stall_i is high; no new request is taken till then
module priority_queue_replace_by_id_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [1:0]                    op_i,
  input  logic [pqrid_pkg::IdBits-1:0]  entry_id_i,
  input  logic signed [pqrid_pkg::PriBits-1:0] entry_priority_i,
  input  logic                          id_from_user_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [2:0]                    status_o,
  output logic [pqrid_pkg::IdBits-1:0]  head_id_o,
  output logic signed [pqrid_pkg::PriBits-1:0] head_priority_o,
  output logic                          head_valid_o,
  output logic                          from_empty_o,
  output logic                          replaced_o,
  output logic [pqrid_pkg::CntBits-1:0] entry_count_o
);
  import pqrid_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // sequencer: load, scan, drop shift, insert shift, bounds, result
  pqrid_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .op_i, .in_stall_o,
    .out_stall_i, .out_valid_o, .cmd_o(cmd), .stat_i(stat)
  );

  // slot storage and scan datapath
  pqrid_dp u_dp (
    .clk_i, .rst_ni, .op_i, .entry_id_i, .entry_priority_i, .id_from_user_i,
    .cmd_i(cmd), .stat_o(stat), .status_o, .head_id_o, .head_priority_o,
    .head_valid_o, .from_empty_o, .replaced_o, .entry_count_o
  );
endmodule

// File: test/priority_queue_replace_by_id_checker.sv
// checker for the sorted priority queue with replace by id: watches both channels,
// predicts each result from its own copy of the queue and compares field by field
// depends on pqrid_pkg
module priority_queue_replace_by_id_checker (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  input  logic                                 in_stall_i,
  input  logic [1:0]                           op_i,
  input  logic [pqrid_pkg::IdBits-1:0]         entry_id_i,
  input  logic signed [pqrid_pkg::PriBits-1:0] entry_priority_i,
  input  logic                                 id_from_user_i,
  input  logic                                 out_valid_i,
  input  logic                                 out_stall_i,
  input  logic [2:0]                           status_i,
  input  logic [pqrid_pkg::IdBits-1:0]         head_id_i,
  input  logic signed [pqrid_pkg::PriBits-1:0] head_priority_i,
  input  logic                                 head_valid_i,
  input  logic                                 from_empty_i,
  input  logic                                 replaced_i,
  input  logic [pqrid_pkg::CntBits-1:0]        entry_count_i,
  output int                                   errors_o,
  output int                                   pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import pqrid_pkg::*;

  typedef struct {
    logic [2:0]                status;
    logic [IdBits-1:0]         head_id;
    logic signed [PriBits-1:0] head_pri;
    logic                      head_valid;
    logic                      from_empty;
    logic                      replaced;
    logic [CntBits-1:0]        count;
  } head_result_t;

  head_result_t              expected_heads[$];
  logic [IdBits-1:0]         q_id[QueueDepth];
  logic signed [PriBits-1:0] q_pri[QueueDepth];
  logic                      q_busy[QueueDepth];
  int                        q_count;
  logic signed [PriBits-1:0] hi_pri, lo_pri;
  logic                      user_seen;

  assign pending_o = expected_heads.size();

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("%0t: %s got %0h want %0h", $realtime, what, got, want);
    errors_o++;
  endtask

  function automatic void drop_entry(input int pos);
    for (int k = pos; k + 1 < q_count; k++) begin
      q_id[k] = q_id[k+1];
      q_pri[k] = q_pri[k+1];
      q_busy[k] = q_busy[k+1];
    end
    q_count--;
  endfunction

  function automatic void put_entry(input int pos, input logic [IdBits-1:0] id,
                                    input logic signed [PriBits-1:0] pri);
    for (int k = q_count; k > pos; k--) begin
      q_id[k] = q_id[k-1];
      q_pri[k] = q_pri[k-1];
      q_busy[k] = q_busy[k-1];
    end
    q_id[pos] = id;
    q_pri[pos] = pri;
    q_busy[pos] = 1'b0;
    q_count++;
  endfunction

  function automatic void update_bounds();
    if (q_count > 0) begin
      hi_pri = q_pri[0];
      lo_pri = q_pri[q_count-1];
    end
  endfunction

  // apply one request to the shadow queue and return the head it leaves behind
  function automatic head_result_t apply_request(input logic [1:0] op,
      input logic [IdBits-1:0] id, input logic signed [PriBits-1:0] pri, input logic user);
    head_result_t r;
    int pos, i;
    bit pos_set, found;
    r.status = StOk;
    r.from_empty = 1'b0;
    r.replaced = 1'b0;
    if (op == OpAdd) begin
      if (q_count >= QueueDepth) begin
        r.status = StFull;
      end else begin
        pos = 0;
        i = 0;
        pos_set = 0;
        r.from_empty = (q_count == 0);
        user_seen = user_seen | user;
        if (user_seen || (pri > lo_pri && pri <= hi_pri)) begin
          // one pass finds the insert point and drops an older copy of the id
          while (i < q_count) begin
            if (!pos_set && pri > q_pri[i]) begin
              pos = i;
              pos_set = 1;
              if (r.replaced) break;
            end
            if (!r.replaced && q_id[i] == id) begin
              drop_entry(i);
              r.replaced = 1'b1;
              if (pos_set && pos == i) break;
              continue;
            end
            i++;
          end
        end
        if (pos_set) put_entry(pos, id, pri);
        else if (pri > hi_pri) put_entry(0, id, pri);
        else put_entry(q_count, id, pri);
        update_bounds();
      end
    end else if (op == OpRemove) begin
      found = 0;
      for (i = 0; i < q_count; i++) begin
        if (q_id[i] == id) begin
          found = 1;
          break;
        end
      end
      if (!found) begin
        r.status = StNotFound;
      end else begin
        drop_entry(i);
        update_bounds();
      end
    end else if (op == OpTake) begin
      if (q_count == 0) r.status = StEmpty;
      else if (q_busy[0]) r.status = StInProcess;
      else q_busy[0] = 1'b1;
    end
    r.head_valid = (q_count > 0);
    r.head_id = r.head_valid ? q_id[0] : '0;
    r.head_pri = r.head_valid ? q_pri[0] : '0;
    r.count = q_count[CntBits-1:0];
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    head_result_t w, nw;
    if (!rst_ni) begin
      expected_heads.delete();
      q_count = 0;
      hi_pri = '0;
      lo_pri = '0;
      user_seen = 1'b0;
      errors_o = 0;
      for (int k = 0; k < QueueDepth; k++) q_busy[k] = 1'b0;
    end else begin
      // results first: a result leaving now belongs to an earlier request
      if (out_valid_i && !out_stall_i) begin
        if (expected_heads.size() == 0) begin
          report("result with no request waiting", 64'(status_i), 64'h0);
        end else begin
          w = expected_heads.pop_front();
          if (status_i !== w.status) report("status", 64'(status_i), 64'(w.status));
          if (head_id_i !== w.head_id) report("head_id", 64'(head_id_i), 64'(w.head_id));
          if (head_priority_i !== w.head_pri)
            report("head_priority", 64'(head_priority_i), 64'(w.head_pri));
          if (head_valid_i !== w.head_valid)
            report("head_valid", 64'(head_valid_i), 64'(w.head_valid));
          if (from_empty_i !== w.from_empty)
            report("from_empty", 64'(from_empty_i), 64'(w.from_empty));
          if (replaced_i !== w.replaced)
            report("replaced", 64'(replaced_i), 64'(w.replaced));
          if (entry_count_i !== w.count)
            report("entry_count", 64'(entry_count_i), 64'(w.count));
        end
      end
      if (in_valid_i && !in_stall_i) begin
        nw = apply_request(op_i, entry_id_i, entry_priority_i, id_from_user_i);
        expected_heads = {expected_heads, nw};
      end
    end
  end
endmodule

// File: test/priority_queue_replace_by_id_top_tb.sv
// testbench top for the sorted priority queue with replace by id: makes the requests,
// drives the result stall pattern and gives the verdict
// depends on pqrid_pkg, priority_queue_replace_by_id_top and the checker module
module priority_queue_replace_by_id_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import pqrid_pkg::*;

  logic                        clk_i;
  logic                        rst_ni;
  logic                        in_valid_i;
  logic                        in_stall_o;
  logic [1:0]                  op_i;
  logic [IdBits-1:0]           entry_id_i;
  logic signed [PriBits-1:0]   entry_priority_i;
  logic                        id_from_user_i;
  logic                        out_valid_o;
  logic                        out_stall_i;
  logic [2:0]                  status_o;
  logic [IdBits-1:0]           head_id_o;
  logic signed [PriBits-1:0]   head_priority_o;
  logic                        head_valid_o;
  logic                        from_empty_o;
  logic                        replaced_o;
  logic [CntBits-1:0]          entry_count_o;
  int                          mismatches;
  int                          outstanding;

  // sender burst bookkeeping
  int burst_left;
  // receiver asks for one long hold-off while requests keep coming
  bit long_hold_req;

  priority_queue_replace_by_id_top DUT (.*);

  priority_queue_replace_by_id_checker u_checker (
    .clk_i, .rst_ni, .in_valid_i,
    .in_stall_i(in_stall_o),
    .op_i, .entry_id_i, .entry_priority_i, .id_from_user_i,
    .out_valid_i(out_valid_o),
    .out_stall_i,
    .status_i(status_o),
    .head_id_i(head_id_o),
    .head_priority_i(head_priority_o),
    .head_valid_i(head_valid_o),
    .from_empty_i(from_empty_o),
    .replaced_i(replaced_o),
    .entry_count_i(entry_count_o),
    .errors_o(mismatches),
    .pending_o(outstanding)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // worst case is far below this: ~1700 requests
  initial begin
    #40ms;
    $display("Mismatches found");
    $finish;
  end

  // receiver: stall pattern changes mode after a random-length run of each mode
  initial begin
    int hold_cnt, mode_cnt, mode;
    hold_cnt = 0;
    mode_cnt = 0;
    mode = 0;
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_stall_i <= 1'b1;
      end else if (long_hold_req) begin
        long_hold_req = 0;
        hold_cnt = 400;
        out_stall_i <= 1'b1;
      end else begin
        if (mode_cnt == 0) begin
          mode = $urandom_range(0, 3);
          mode_cnt = $urandom_range(50, 300);
        end
        mode_cnt--;
        case (mode)
          0: out_stall_i <= 1'b0;                          // no back-pressure
          1: out_stall_i <= ($urandom_range(0, 99) < 30);
          2: out_stall_i <= ($urandom_range(0, 99) < 75);
          default: out_stall_i <= (mode_cnt % 7) < 3;      // periodic
        endcase
      end
    end
  end

  // one request: optional idle gap at a burst boundary, then hold until accepted
  task automatic send_request(input logic [1:0] op, input logic [IdBits-1:0] id,
                              input logic signed [PriBits-1:0] pri, input logic user);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i <= 1'b1;
    op_i <= op;
    entry_id_i <= id;
    entry_priority_i <= pri;
    id_from_user_i <= user;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  function automatic logic [IdBits-1:0] pick_id();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return IdBits'($urandom_range(0, 7));
    if (r < 80) return $urandom_range(0, 1) ? '1 : '0;
    return IdBits'($urandom);
  endfunction

  function automatic logic signed [PriBits-1:0] pick_priority();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return PriBits'($urandom_range(0, 8)) - 16'sd4;
    if (r < 80) return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
    return PriBits'($urandom);
  endfunction

  initial begin
    logic [1:0] op;
    int w;
    burst_left = 0;
    long_hold_req = 0;
    in_valid_i = 1'b0;
    op_i = OpAdd;
    entry_id_i = '0;
    entry_priority_i = '0;
    id_from_user_i = 1'b0;
    rst_ni = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty-queue cases, unused op, extremes, no-scan placement
    send_request(OpTake, '0, '0, 1'b0);                    // take on empty
    send_request(OpRemove, 32'h1234, '0, 1'b0);            // remove of absent id
    send_request(OpUnused, '1, '1, 1'b1);                  // unused code, must not set user flag
    send_request(OpAdd, '0, 16'sd0, 1'b0);                 // add to empty, goes to back
    send_request(OpAdd, '1, 16'sh7fff, 1'b0);              // above highest, to front
    send_request(OpAdd, 32'd5, 16'sh8000, 1'b0);           // at or below lowest, to back
    send_request(OpAdd, 32'd6, 16'sd100, 1'b0);            // inside bounds, scan and insert
    send_request(OpAdd, 32'd6, 16'sd50, 1'b0);             // scan drops older copy of id
    send_request(OpTake, '0, '0, 1'b0);
    send_request(OpTake, '0, '0, 1'b0);                    // head already in process
    send_request(OpRemove, '1, '0, 1'b0);                  // remove the in-process head
    // fill the queue without user ids, then an add to a full queue with the user bit
    for (int k = 0; k < 13; k++) send_request(OpAdd, 32'(100 + k), pick_priority(), 1'b0);
    send_request(OpAdd, 32'd7, 16'sd1, 1'b1);              // full: user flag stays clear
    send_request(OpRemove, 32'd5, '0, 1'b0);
    send_request(OpAdd, 32'd100, 16'sh7fff, 1'b0);          // top priority: to the front if above highest, else a scan
    send_request(OpAdd, 32'd100, 16'sd3, 1'b1);            // user id turns scans on for good

    // random: add-heavy and remove-heavy phases so occupancy sweeps empty to full
    for (int n = 0; n < 1600; n++) begin
      if (n == 400) long_hold_req = 1;
      w = $urandom_range(0, 99);
      if ((n / 80) % 2 == 0)
        op = (w < 60) ? OpAdd : (w < 80) ? OpRemove : (w < 95) ? OpTake : OpUnused;
      else op = (w < 25) ? OpAdd : (w < 75) ? OpRemove : (w < 95) ? OpTake : OpUnused;
      send_request(op, pick_id(), pick_priority(), 1'($urandom_range(0, 1)));
    end
    in_valid_i <= 1'b0;

    while (outstanding != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule

// File: priority_queue_replace_by_id_top.f
hw/rtl/pqrid_pkg.sv
hw/rtl/pqrid_ctrl.sv
hw/rtl/pqrid_dp.sv
hw/rtl/priority_queue_replace_by_id_top.sv
test/priority_queue_replace_by_id_checker.sv
test/priority_queue_replace_by_id_top_tb.sv
